/* hdl/dtq_pkg.sv */
// Package for the delay-ordered timer queue: word types, codes and defaults.
`default_nettype none
package dtq_pkg;

    // Default sizing
    localparam int SLOTS_DEFAULT      = 16;
    localparam int DELAY_BITS_DEFAULT = 16;

    // Field widths of the channel words
    localparam int MODE_W    = 2;
    localparam int ID_W      = 8;
    localparam int TIME_W    = 16;
    localparam int STATUS_W  = 2;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_SUBMIT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PASSED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd2;

    // Result codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd2;

    // Input word
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   item_id;
        logic [TIME_W-1:0] submit_delay;
        logic [TIME_W-1:0] elapsed;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     popped_id;
    } out_word_t;

    // Command broadcast to every cell in the row
    typedef struct packed {
        logic insert;   // place new entry in order, shift the tail down
        logic age;      // subtract elapsed time, saturating at zero
        logic pop;      // shift every entry one place towards the head
    } cell_cmd_t;

endpackage
`default_nettype wire

/* hdl/delta_timer_queue_top.sv */
// Timer queue over a row of sorted slot cells: one request per cycle unless stalled.
// The result word is registered in the cycle after the request word is taken.
// One word per cycle unless stalled; cells update in parallel with their neighbours.
// Insert, age and pop each update all SLOTS cells of the row together.
// Reset empties the queue (fill count zero) and clears the pending result.
`default_nettype none
module delta_timer_queue_top #(
    parameter int SLOTS      = dtq_pkg::SLOTS_DEFAULT,
    parameter int DELAY_BITS = dtq_pkg::DELAY_BITS_DEFAULT
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire dtq_pkg::in_word_t in_word,
    output logic                out_valid,
    input  wire                 out_stall,
    output dtq_pkg::out_word_t  out_word
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int W  = (DELAY_BITS > dtq_pkg::TIME_W) ? DELAY_BITS : dtq_pkg::TIME_W;
    localparam logic [W-1:0] DMAX = W'((64'd1 << DELAY_BITS) - 64'd1);

    logic [CW-1:0]          count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    dtq_pkg::out_word_t     out_word_reg, out_word_next;

    logic                   accept;
    logic [W-1:0]           delay_ext, elapsed_ext;
    logic [DELAY_BITS-1:0]  delay_sat, elapsed_sat, value;
    logic                   full, head_due;
    dtq_pkg::cell_cmd_t     cmd;

    logic [dtq_pkg::ID_W-1:0] item_q [SLOTS];
    logic [DELAY_BITS-1:0]    rem_q  [SLOTS];
    logic [SLOTS-1:0]         keep_q;

    // Handshake: result register parts the two sides
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Saturate times into the slot width
    assign delay_ext   = W'(in_word.submit_delay);
    assign elapsed_ext = W'(in_word.elapsed);
    assign delay_sat   = (delay_ext > DMAX) ? DMAX[DELAY_BITS-1:0] : delay_ext[DELAY_BITS-1:0];
    assign elapsed_sat = (elapsed_ext > DMAX) ? DMAX[DELAY_BITS-1:0]
                                              : elapsed_ext[DELAY_BITS-1:0];
    assign value = (in_word.mode == dtq_pkg::MODE_SUBMIT) ? delay_sat : elapsed_sat;

    assign full     = (count_reg == CW'(SLOTS));
    assign head_due = (count_reg != '0) && (rem_q[0] == '0);

    // Command decode
    always_comb
    begin
        cmd        = '0;
        cmd.insert = accept && (in_word.mode == dtq_pkg::MODE_SUBMIT) && !full;
        cmd.age    = accept && (in_word.mode == dtq_pkg::MODE_PASSED)
                     && (in_word.elapsed != '0);
        cmd.pop    = accept && (in_word.mode == dtq_pkg::MODE_POP) && head_due;
    end

    // Row of cells
    genvar k;
    generate
        for (k = 0; k < SLOTS; k++)
        begin : g_cell
            logic                     in_use;
            logic                     p_keep;
            logic [dtq_pkg::ID_W-1:0] p_item, n_item;
            logic [DELAY_BITS-1:0]    p_rem, n_rem;

            assign in_use = (CW'(k) < count_reg);

            // head: nothing ahead of it, so a new entry that sorts first lands here
            if (k == 0)
            begin : g_head
                assign p_keep = 1'b1;
                assign p_item = item_q[k];
                assign p_rem  = rem_q[k];
            end
            else
            begin : g_body
                assign p_keep = keep_q[k-1];
                assign p_item = item_q[k-1];
                assign p_rem  = rem_q[k-1];
            end

            if (k == SLOTS - 1)
            begin : g_tail
                assign n_item = item_q[k];
                assign n_rem  = rem_q[k];
            end
            else
            begin : g_inner
                assign n_item = item_q[k+1];
                assign n_rem  = rem_q[k+1];
            end

            dtq_cell #(
                .DELAY_BITS (DELAY_BITS)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .in_use    (in_use),
                .value     (value),
                .new_id    (in_word.item_id),
                .prev_keep (p_keep),
                .prev_item (p_item),
                .prev_rem  (p_rem),
                .next_item (n_item),
                .next_rem  (n_rem),
                .keep      (keep_q[k]),
                .item      (item_q[k]),
                .rem       (rem_q[k])
            );
        end
    endgenerate

    // Fill count and result word
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
        end
        if (accept)
        begin
            out_valid_next          = 1'b1;
            out_word_next.status    = dtq_pkg::STATUS_OK;
            out_word_next.popped_id = '0;
            case (in_word.mode)
                dtq_pkg::MODE_SUBMIT:
                begin
                    if (full)
                    begin
                        out_word_next.status = dtq_pkg::STATUS_FULL;
                    end
                end
                dtq_pkg::MODE_POP:
                begin
                    if (head_due)
                    begin
                        out_word_next.popped_id = item_q[0];
                    end
                    else
                    begin
                        out_word_next.status = dtq_pkg::STATUS_NONE;
                    end
                end
                default:
                begin
                    out_word_next.status = dtq_pkg::STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
`default_nettype wire

/* hdl/dtq_cell.sv */
// One slot of the sorted timer row: item id and remaining time.
`default_nettype none
module dtq_cell #(
    parameter int DELAY_BITS = dtq_pkg::DELAY_BITS_DEFAULT
) (
    input  wire                         clk,
    input  wire dtq_pkg::cell_cmd_t     cmd,
    input  wire                         in_use,
    input  wire [DELAY_BITS-1:0]        value,
    input  wire [dtq_pkg::ID_W-1:0]     new_id,
    input  wire                         prev_keep,
    input  wire [dtq_pkg::ID_W-1:0]     prev_item,
    input  wire [DELAY_BITS-1:0]        prev_rem,
    input  wire [dtq_pkg::ID_W-1:0]     next_item,
    input  wire [DELAY_BITS-1:0]        next_rem,
    output logic                        keep,
    output logic [dtq_pkg::ID_W-1:0]    item,
    output logic [DELAY_BITS-1:0]       rem
);

    logic [dtq_pkg::ID_W-1:0] item_reg, item_next;
    logic [DELAY_BITS-1:0]    rem_reg, rem_next;

    // Entry stays put on insert when it expires no later than the new one
    assign keep = in_use && (rem_reg <= value);

    always_comb
    begin
        item_next = item_reg;
        rem_next  = rem_reg;
        if (cmd.insert)
        begin
            if (!keep)
            begin
                if (prev_keep)
                begin
                    item_next = new_id;
                    rem_next  = value;
                end
                else
                begin
                    item_next = prev_item;
                    rem_next  = prev_rem;
                end
            end
        end
        else if (cmd.age)
        begin
            rem_next = (rem_reg > value) ? (rem_reg - value) : '0;
        end
        else if (cmd.pop)
        begin
            item_next = next_item;
            rem_next  = next_rem;
        end
    end

    // Slot contents, no reset
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rem_reg  <= rem_next;
    end

    assign item = item_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire
